// ===== hw/rtl/ptrc_pkg.sv =====
// Package for the packet traffic rate counter: word layouts, command codes,
// bucket entry layout and the controller/datapath command and status types.
// No dependencies.
package ptrc_pkg;

  localparam int TS_W   = 64;
  localparam int CNT_W  = 64;
  localparam int BYTE_W = 32;

  localparam logic [1:0] CMD_RECORD   = 2'd0;
  localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // The constant divider retires this many dividend bits per cycle.
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = TS_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic [1:0]        cmd;
    logic              direction;
    logic [BYTE_W-1:0] byte_count;
    logic [TS_W-1:0]   now_ms;
  } in_word_t;

  typedef struct packed {
    logic [TS_W-1:0]  captured_ms;
    logic [CNT_W-1:0] in_packets_total;
    logic [CNT_W-1:0] out_packets_total;
    logic [CNT_W-1:0] in_bytes_total;
    logic [CNT_W-1:0] out_bytes_total;
    logic [CNT_W-1:0] in_packets_window;
    logic [CNT_W-1:0] out_packets_window;
    logic [CNT_W-1:0] in_bytes_window;
    logic [CNT_W-1:0] out_bytes_window;
  } out_word_t;

  typedef struct packed {
    logic [TS_W-1:0]  start;
    logic [CNT_W-1:0] in_packets;
    logic [CNT_W-1:0] out_packets;
    logic [CNT_W-1:0] in_bytes;
    logic [CNT_W-1:0] out_bytes;
  } bkt_t;

  localparam int BKT_W = $bits(bkt_t);

  typedef struct packed {
    logic load;      // capture the input word, prime divider and accumulators
    logic clr;       // zero totals and invalidate every bucket
    logic div_step;  // retire DIV_BITS dividend bits
    logic rec_rd;    // read the bucket selected by the record timestamp
    logic rec_upd;   // update totals and write the bucket back
    logic scan_rd;   // read the next bucket of a snapshot scan
    logic emit;      // load the output word
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/ptrc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ptrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ptrc_ctrl.sv =====
// Controller state machine of the packet traffic rate counter.
// Depends on ptrc_pkg for command codes and the datapath command/status types.
module ptrc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_cmd,
  output logic              busy,
  output logic              out_valid,
  output ptrc_pkg::dp_cmd_t dp_cmd,
  input  ptrc_pkg::dp_stat_t dp_stat
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_DRN1 = 3'd5;
  localparam logic [2:0] ST_DRN2 = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]                     state_r, state_nxt;
  logic [ptrc_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dp_cmd    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_cmd)
            ptrc_pkg::CMD_RECORD: begin
              dp_cmd.load = 1'b1;
              cnt_nxt     = '0;
              state_nxt   = ST_DIV;
            end
            ptrc_pkg::CMD_SNAPSHOT: begin
              dp_cmd.load = 1'b1;
              state_nxt   = ST_SCAN;
            end
            ptrc_pkg::CMD_CLEAR: begin
              dp_cmd.clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        dp_cmd.div_step = 1'b1;
        cnt_nxt         = cnt_r + 1'b1;
        if (cnt_r == ptrc_pkg::DIV_CNT_W'(ptrc_pkg::DIV_CYCLES - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        dp_cmd.rec_rd = 1'b1;
        state_nxt     = ST_UPD;
      end
      ST_UPD: begin
        dp_cmd.rec_upd = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        dp_cmd.scan_rd = 1'b1;
        if (dp_stat.scan_last) begin
          state_nxt = ST_DRN1;
        end
      end
      ST_DRN1: begin
        state_nxt = ST_DRN2;
      end
      ST_DRN2: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        dp_cmd.emit = 1'b1;
        state_nxt   = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == ST_EMIT);
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/ptrc_dp.sv =====
// Datapath of the packet traffic rate counter: constant divider, totals,
// bucket store with valid bits, snapshot scan pipeline and output register.
// Depends on ptrc_pkg and ptrc_ram.
module ptrc_dp #(
  parameter int BUCKETS   = 8,
  parameter int BUCKET_MS = 125
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptrc_pkg::in_word_t  in_word,
  input  ptrc_pkg::dp_cmd_t   dp_cmd,
  output ptrc_pkg::dp_stat_t  dp_stat,
  output ptrc_pkg::out_word_t out_word
);

  localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = $clog2(BUCKET_MS) + 1;
  localparam int MW = $clog2(BUCKETS) + 1;
  localparam logic [RW:0] DIVISOR = (RW + 1)'(BUCKET_MS);
  localparam logic [MW:0] MODULUS = (MW + 1)'(BUCKETS);
  localparam logic [ptrc_pkg::TS_W-1:0] WINDOW_MS =
    ptrc_pkg::TS_W'(BUCKETS) * ptrc_pkg::TS_W'(BUCKET_MS);

  // Captured command word.
  logic [ptrc_pkg::TS_W-1:0]   now_r;
  logic                        dir_r;
  logic [ptrc_pkg::BYTE_W-1:0] bytes_r;

  // Divider state: dividend bits still to go, remainder, and slot mod BUCKETS.
  logic [ptrc_pkg::TS_W-1:0] num_r, num_nxt;
  logic [RW-1:0]             rem_r, rem_nxt;
  logic [MW-1:0]             mod_r, mod_nxt;
  logic [ptrc_pkg::TS_W-1:0] start_r;
  logic [AW-1:0]             idx;

  logic [BUCKETS-1:0]         used_r;
  logic [ptrc_pkg::CNT_W-1:0] in_pkt_r, out_pkt_r, in_byte_r, out_byte_r;

  logic [AW-1:0]         ptr_r;
  logic                  s1_vld_r, s1_used_r;
  logic                  s2_inc_r;
  ptrc_pkg::bkt_t        s2_bkt_r;
  logic [ptrc_pkg::CNT_W-1:0] acc_ip_r, acc_op_r, acc_ib_r, acc_ob_r;
  ptrc_pkg::out_word_t   out_r;

  ptrc_pkg::bkt_t        rd_bkt, wr_bkt;
  logic [AW-1:0]         raddr;
  logic                  hit;
  logic [ptrc_pkg::TS_W:0] diff;

  // Restoring division by BUCKET_MS, DIV_BITS quotient bits per cycle. The
  // quotient is only needed modulo BUCKETS, so it is folded as it is formed.
  always_comb begin
    logic [RW:0] t;
    logic [MW:0] mt;
    logic        qb;
    rem_nxt = rem_r;
    mod_nxt = mod_r;
    num_nxt = num_r;
    for (int k = 0; k < ptrc_pkg::DIV_BITS; k++) begin
      t       = {rem_nxt, num_nxt[ptrc_pkg::TS_W-1]};
      num_nxt = {num_nxt[ptrc_pkg::TS_W-2:0], 1'b0};
      qb      = (t >= DIVISOR);
      if (qb) begin
        t = t - DIVISOR;
      end
      rem_nxt = t[RW-1:0];
      mt      = {mod_nxt, qb};
      if (mt >= MODULUS) begin
        mt = mt - MODULUS;
      end
      mod_nxt = mt[MW-1:0];
    end
  end

  assign idx               = mod_r[AW-1:0];
  assign raddr             = dp_cmd.scan_rd ? ptr_r : idx;
  assign dp_stat.scan_last = (ptr_r == AW'(BUCKETS - 1));

  // Bucket update: a stale or never used bucket restarts from zero.
  always_comb begin
    hit = used_r[idx] && (rd_bkt.start == start_r);
    wr_bkt = hit ? rd_bkt : '0;
    wr_bkt.start = start_r;
    if (dir_r) begin
      wr_bkt.out_packets = wr_bkt.out_packets + 1'b1;
      wr_bkt.out_bytes   = wr_bkt.out_bytes + ptrc_pkg::CNT_W'(bytes_r);
    end else begin
      wr_bkt.in_packets  = wr_bkt.in_packets + 1'b1;
      wr_bkt.in_bytes    = wr_bkt.in_bytes + ptrc_pkg::CNT_W'(bytes_r);
    end
  end

  assign diff = {1'b0, now_r} - {1'b0, rd_bkt.start};

  ptrc_ram #(
    .WIDTH(ptrc_pkg::BKT_W),
    .DEPTH(BUCKETS)
  ) u_bkt_ram (
    .clk  (clk),
    .we   (dp_cmd.rec_upd),
    .waddr(idx),
    .wdata(wr_bkt),
    .raddr(raddr),
    .rdata(rd_bkt)
  );

  // Control state and architectural totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      in_pkt_r   <= '0;
      out_pkt_r  <= '0;
      in_byte_r  <= '0;
      out_byte_r <= '0;
      ptr_r      <= '0;
      s1_vld_r   <= 1'b0;
      s1_used_r  <= 1'b0;
      s2_inc_r   <= 1'b0;
    end else begin
      if (dp_cmd.clr) begin
        used_r     <= '0;
        in_pkt_r   <= '0;
        out_pkt_r  <= '0;
        in_byte_r  <= '0;
        out_byte_r <= '0;
      end else if (dp_cmd.rec_upd) begin
        used_r[idx] <= 1'b1;
        if (dir_r) begin
          out_pkt_r  <= out_pkt_r + 1'b1;
          out_byte_r <= out_byte_r + ptrc_pkg::CNT_W'(bytes_r);
        end else begin
          in_pkt_r   <= in_pkt_r + 1'b1;
          in_byte_r  <= in_byte_r + ptrc_pkg::CNT_W'(bytes_r);
        end
      end
      if (dp_cmd.scan_rd) begin
        ptr_r <= dp_stat.scan_last ? '0 : ptr_r + 1'b1;
      end
      s1_vld_r  <= dp_cmd.scan_rd;
      s1_used_r <= used_r[ptr_r];
      s2_inc_r  <= s1_vld_r && s1_used_r && !diff[ptrc_pkg::TS_W] &&
                   (diff[ptrc_pkg::TS_W-1:0] < WINDOW_MS);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      now_r   <= in_word.now_ms;
      dir_r   <= in_word.direction;
      bytes_r <= in_word.byte_count;
      num_r   <= in_word.now_ms;
      rem_r   <= '0;
      mod_r   <= '0;
    end else if (dp_cmd.div_step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      mod_r <= mod_nxt;
    end
    if (dp_cmd.rec_rd) begin
      start_r <= now_r - ptrc_pkg::TS_W'(rem_r);
    end
    s2_bkt_r <= rd_bkt;
    if (dp_cmd.load) begin
      acc_ip_r <= '0;
      acc_op_r <= '0;
      acc_ib_r <= '0;
      acc_ob_r <= '0;
    end else if (s2_inc_r) begin
      acc_ip_r <= acc_ip_r + s2_bkt_r.in_packets;
      acc_op_r <= acc_op_r + s2_bkt_r.out_packets;
      acc_ib_r <= acc_ib_r + s2_bkt_r.in_bytes;
      acc_ob_r <= acc_ob_r + s2_bkt_r.out_bytes;
    end
    if (dp_cmd.emit) begin
      out_r.captured_ms        <= now_r;
      out_r.in_packets_total   <= in_pkt_r;
      out_r.out_packets_total  <= out_pkt_r;
      out_r.in_bytes_total     <= in_byte_r;
      out_r.out_bytes_total    <= out_byte_r;
      out_r.in_packets_window  <= acc_ip_r;
      out_r.out_packets_window <= acc_op_r;
      out_r.in_bytes_window    <= acc_ib_r;
      out_r.out_bytes_window   <= acc_ob_r;
    end
  end

  assign out_word = out_r;

endmodule

// ===== hw/rtl/packet_traffic_rate_counter_top.sv =====
// Top level of the packet traffic rate counter.
// Depends on ptrc_pkg, ptrc_ctrl, ptrc_dp and (through the datapath) ptrc_ram.
//
// The block keeps 64-bit wrapping packet and byte totals per direction and a
// ring of BUCKETS time buckets, each BUCKET_MS milliseconds wide. A command
// word is taken at a clock edge where start is high and busy is low. A record
// word keeps busy high while the divider divides the 64-bit timestamp by
// BUCKET_MS four bits at a time and the bucket is then read from its RAM
// and written back; no new word is taken meanwhile. A snapshot word scans
// the bucket RAM one entry per cycle through its single read port, and its
// result word appears in the first cycle that busy is low again, once the
// last bucket read has passed through the accumulators. A clear word, and
// the unused command code, finish at once and leave busy low.
// Clear invalidates all buckets through per-bucket valid bits, so there is no
// clearing pass after reset or clear. The result word is shown on out_word
// for exactly one cycle while out_valid is high; the receiver cannot stall
// it, and no other result can follow in the next cycle.
module packet_traffic_rate_counter_top #(
  parameter int BUCKETS   = 8,
  parameter int BUCKET_MS = 125
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptrc_pkg::in_word_t  in_word,
  output logic                out_valid,
  output ptrc_pkg::out_word_t out_word
);

  ptrc_pkg::dp_cmd_t  dp_cmd;
  ptrc_pkg::dp_stat_t dp_stat;

  // The controller sequences each command; the datapath holds all counters.
  ptrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_cmd   (in_word.cmd),
    .busy     (busy),
    .out_valid(out_valid),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  ptrc_dp #(
    .BUCKETS  (BUCKETS),
    .BUCKET_MS(BUCKET_MS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .dp_cmd  (dp_cmd),
    .dp_stat (dp_stat),
    .out_word(out_word)
  );

endmodule

// ===== hw/rtl/ptrc_chk.sv =====
// Port-level checker for the packet traffic rate counter, bound to the top.
// Depends on ptrc_pkg for the input word type and command codes.
module ptrc_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ptrc_pkg::in_word_t in_word,
  input logic               out_valid
);

  // A result word is a single-cycle strobe.
  a_out_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // The result is presented only once the block is ready for the next word.
  a_out_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while busy");

  // Record and snapshot words occupy the block.
  a_work_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.cmd == ptrc_pkg::CMD_RECORD ||
                        in_word.cmd == ptrc_pkg::CMD_SNAPSHOT)) |=> busy)
    else $error("record or snapshot word did not raise busy");

  // Clear completes in the cycle it is taken.
  a_clear_fast : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.cmd == ptrc_pkg::CMD_CLEAR) |=> !busy)
    else $error("clear word raised busy");

  // No result without a snapshot somewhere before it.
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy)) |-> !out_valid)
    else $error("result word without a finished snapshot");

endmodule

bind packet_traffic_rate_counter_top ptrc_chk u_ptrc_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_word  (in_word),
  .out_valid(out_valid)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for packet_traffic_rate_counter_top.
// Depends on ptrc_pkg and the RTL of the block; needs no files or arguments.
module tb;
  import ptrc_pkg::*;

  localparam int BUCKETS     = 8;
  localparam int BUCKET_MS   = 125;
  localparam int ITEMS       = 1300;
  // Longest quiet stretch of a correct run is a record's busy period after
  // the longest hold, so this leaves a wide margin.
  localparam int STALL_LIMIT = 500;
  localparam int MAX_REPORTS = 40;
  localparam int N_FIELDS    = 9;
  // The command field has one code that the block leaves unused.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    in_word_t    word;
    int unsigned hold;
  } cmd_item_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  packet_traffic_rate_counter_top #(
    .BUCKETS  (BUCKETS),
    .BUCKET_MS(BUCKET_MS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    #5 clk = ~clk;
  end

  // Command words waiting to be driven, and the snapshot words the block
  // still owes us, oldest first.
  cmd_item_t   cmd_queue[$];
  out_word_t   snapshot_queue[$];
  int unsigned hold_cnt = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_cnt = 0;
  int unsigned report_cnt = 0;
  bit          no_gaps = 1'b0;

  string field_names[N_FIELDS] = '{
    "captured_ms", "in_packets_total", "out_packets_total", "in_bytes_total",
    "out_bytes_total", "in_packets_window", "out_packets_window",
    "in_bytes_window", "out_bytes_window"
  };

  // Our own copy of the traffic statistics: running totals per direction and
  // the ring of time buckets with their tags.
  logic [63:0] in_pkt_total, out_pkt_total, in_byte_total, out_byte_total;
  logic        bkt_valid[BUCKETS];
  logic [63:0] bkt_start[BUCKETS];
  logic [63:0] bkt_in_pkts[BUCKETS];
  logic [63:0] bkt_out_pkts[BUCKETS];
  logic [63:0] bkt_in_bytes[BUCKETS];
  logic [63:0] bkt_out_bytes[BUCKETS];

  function automatic void clear_traffic();
    in_pkt_total   = '0;
    out_pkt_total  = '0;
    in_byte_total  = '0;
    out_byte_total = '0;
    for (int b = 0; b < BUCKETS; b++) begin
      bkt_valid[b]     = 1'b0;
      bkt_start[b]     = '0;
      bkt_in_pkts[b]   = '0;
      bkt_out_pkts[b]  = '0;
      bkt_in_bytes[b]  = '0;
      bkt_out_bytes[b] = '0;
    end
  endfunction

  // Applies one accepted command word to the statistics and, for a snapshot,
  // queues the word the block must return.
  function automatic void apply_command(input in_word_t w);
    logic [63:0] slot;
    logic [63:0] slot_start;
    logic [63:0] window_ms;
    int unsigned idx;
    out_word_t   snap;
    case (w.cmd)
      CMD_RECORD: begin
        slot       = w.now_ms / 64'(BUCKET_MS);
        slot_start = slot * 64'(BUCKET_MS);
        idx        = 32'(slot % 64'(BUCKETS));
        // A bucket still tagged with an older interval starts over.
        if (!bkt_valid[idx] || bkt_start[idx] != slot_start) begin
          bkt_valid[idx]     = 1'b1;
          bkt_start[idx]     = slot_start;
          bkt_in_pkts[idx]   = '0;
          bkt_out_pkts[idx]  = '0;
          bkt_in_bytes[idx]  = '0;
          bkt_out_bytes[idx] = '0;
        end
        if (w.direction == 1'b0) begin
          in_pkt_total       += 64'd1;
          in_byte_total      += 64'(w.byte_count);
          bkt_in_pkts[idx]   += 64'd1;
          bkt_in_bytes[idx]  += 64'(w.byte_count);
        end else begin
          out_pkt_total      += 64'd1;
          out_byte_total     += 64'(w.byte_count);
          bkt_out_pkts[idx]  += 64'd1;
          bkt_out_bytes[idx] += 64'(w.byte_count);
        end
      end
      CMD_SNAPSHOT: begin
        window_ms = 64'(BUCKETS) * 64'(BUCKET_MS);
        snap = '0;
        snap.captured_ms       = w.now_ms;
        snap.in_packets_total  = in_pkt_total;
        snap.out_packets_total = out_pkt_total;
        snap.in_bytes_total    = in_byte_total;
        snap.out_bytes_total   = out_byte_total;
        // Only buckets that start inside the last window and not after the
        // query time are summed.
        for (int b = 0; b < BUCKETS; b++) begin
          if (bkt_valid[b] && bkt_start[b] <= w.now_ms &&
              w.now_ms - bkt_start[b] < window_ms) begin
            snap.in_packets_window  += bkt_in_pkts[b];
            snap.out_packets_window += bkt_out_pkts[b];
            snap.in_bytes_window    += bkt_in_bytes[b];
            snap.out_bytes_window   += bkt_out_bytes[b];
          end
        end
        snapshot_queue.push_back(snap);
      end
      CMD_CLEAR: begin
        clear_traffic();
      end
      default: begin
        // The unused code leaves everything as it was.
      end
    endcase
  endfunction

  // Driver. A word is taken at an edge where start is high and busy is low.
  // The next word goes out once its hold (counted from the moment the line
  // is free) has passed; with no hold, start simply stays high.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      hold_cnt <= 0;
      clear_traffic();
    end else begin
      if (start && !busy) begin
        apply_command(in_word);
      end
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && hold_cnt >= cmd_queue[0].hold) begin
          in_word  <= cmd_queue[0].word;
          start    <= 1'b1;
          hold_cnt <= 0;
          cmd_queue.delete(0);
        end else begin
          start <= 1'b0;
          if (cmd_queue.size() != 0) begin
            hold_cnt <= hold_cnt + 1;
          end
        end
      end
    end
  end

  // Monitor. Every snapshot word is compared field by field with the oldest
  // expected word; the block cannot be stalled, so each strobe is one word.
  always @(posedge clk) begin
    out_word_t exp_word;
    logic [63:0] exp_field;
    logic [63:0] got_field;
    if (rst_n && out_valid) begin
      if (snapshot_queue.size() == 0) begin
        fail_cnt++;
        if (report_cnt < MAX_REPORTS) begin
          report_cnt++;
          $display("%0t ns: unexpected snapshot word, expected none, got %h",
                   $time, out_word);
        end
      end else begin
        exp_word = snapshot_queue.pop_front();
        for (int f = 0; f < N_FIELDS; f++) begin
          exp_field = exp_word[$bits(out_word_t) - 64 * (f + 1) +: 64];
          got_field = out_word[$bits(out_word_t) - 64 * (f + 1) +: 64];
          if (got_field !== exp_field) begin
            fail_cnt++;
            if (report_cnt < MAX_REPORTS) begin
              report_cnt++;
              $display("%0t ns: %s expected %h, got %h",
                       $time, field_names[f], exp_field, got_field);
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_cmd(input logic [1:0] cmd, input logic dir,
                          input logic [31:0] nbytes, input logic [63:0] now);
    cmd_item_t item;
    item.word.cmd        = cmd;
    item.word.direction  = dir;
    item.word.byte_count = nbytes;
    item.word.now_ms     = now;
    item.hold            = no_gaps ? 0 : $urandom_range(0, 7);
    cmd_queue.push_back(item);
  endtask

  function automatic logic [31:0] pick_bytes();
    case ($urandom_range(0, 5))
      0: return 32'($urandom);
      1: return '1;
      2: return '0;
      default: return 32'($urandom_range(40, 1600));
    endcase
  endfunction

  initial begin
    int unsigned traffic_cnt;
    int unsigned burst_len;
    int unsigned pick;
    logic [63:0] clock_ms;
    logic [63:0] query_ms;
    traffic_cnt = 0;

    // Directed part. It walks the window edges: a bucket exactly one window
    // old, a bucket that starts after the query, a ring slot reused by a
    // later interval, the timestamp extremes, the unused code and clear.
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, '0);
    push_cmd(CMD_RECORD, 1'b0, '0, 64'd0);
    push_cmd(CMD_RECORD, 1'b1, '1, 64'd124);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, 64'd124);
    push_cmd(CMD_RECORD, 1'b0, 32'd1500, 64'd125);
    push_cmd(CMD_SNAPSHOT, 1'b1, '1, 64'd999);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, 64'd1000);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, 64'd100);
    push_cmd(CMD_RECORD, 1'b1, 32'd7, 64'd1000);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, 64'd1000);
    push_cmd(CMD_UNUSED, 1'($urandom), 32'($urandom), {$urandom, $urandom});
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, 64'd1124);
    push_cmd(CMD_RECORD, 1'b0, '1, '1);
    push_cmd(CMD_RECORD, 1'b1, 32'h8000_0000, '1 - 64'd125);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, '1);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, '0);
    push_cmd(CMD_CLEAR, 1'b1, '1, '1);
    push_cmd(CMD_SNAPSHOT, 1'b1, '1, '1);
    push_cmd(CMD_RECORD, 1'b0, 32'd3, 64'd42);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, 64'd42);
    push_cmd(CMD_CLEAR, 1'b0, '0, '0);
    push_cmd(CMD_SNAPSHOT, 1'b0, '0, 64'd42);
    traffic_cnt = 21;

    // Random part: bursts of traffic on a clock that moves forward, each from
    // a fresh base time, with jumps over a bucket width now and then, stale or
    // early queries, clears, and out-of-order timestamps as noise. Some bursts
    // run back to back with no holds at all.
    while (traffic_cnt < ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: clock_ms = {$urandom, $urandom};
        1: clock_ms = '1 - 64'($urandom_range(0, 4000));
        default: clock_ms = 64'($urandom_range(0, 20000));
      endcase
      burst_len = $urandom_range(10, 50);
      for (int k = 0; k < burst_len; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          clock_ms += 64'($urandom_range(126, 1500));
        end else begin
          clock_ms += 64'($urandom_range(0, 60));
        end
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          push_cmd(CMD_RECORD, 1'($urandom), pick_bytes(), clock_ms);
          traffic_cnt++;
        end else if (pick < 88) begin
          case ($urandom_range(0, 3))
            0: query_ms = clock_ms - 64'($urandom_range(0, 250));
            1: query_ms = clock_ms + 64'($urandom_range(0, 1200));
            default: query_ms = clock_ms;
          endcase
          push_cmd(CMD_SNAPSHOT, 1'($urandom), 32'($urandom), query_ms);
          traffic_cnt++;
        end else if (pick < 91) begin
          push_cmd(CMD_CLEAR, 1'($urandom), 32'($urandom), {$urandom, $urandom});
          traffic_cnt++;
        end else if (pick < 94) begin
          push_cmd(CMD_UNUSED, 1'($urandom), 32'($urandom), {$urandom, $urandom});
        end else begin
          push_cmd(CMD_RECORD, 1'($urandom), pick_bytes(), {$urandom, $urandom});
          traffic_cnt++;
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken and every snapshot word to come back,
    // then give the block a snapshot's latency and some margin to misbehave.
    @(posedge clk);
    while (cmd_queue.size() != 0 || start || snapshot_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (BUCKETS + 24) @(posedge clk);

    if (snapshot_queue.size() != 0) begin
      fail_cnt++;
      $display("%0t ns: %0d snapshot words never arrived", $time,
               snapshot_queue.size());
    end
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ptrc_pkg.sv
hw/rtl/ptrc_ram.sv
hw/rtl/ptrc_ctrl.sv
hw/rtl/ptrc_dp.sv
hw/rtl/packet_traffic_rate_counter_top.sv
hw/rtl/ptrc_chk.sv
test/tb.sv
